// ----- src/ctg_pkg.sv -----
// ctg_pkg: shared types and constants of the cubic trajectory generator
// holds controller states, datapath operation codes and the command/status structs
// no dependencies
package ctg_pkg;

  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam logic [63:0] COEF_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_TIME,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_END,
    ST_ADD,
    ST_CONV,
    ST_OFFS,
    ST_DONE
  } ctg_state_e;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_C
  } ctg_phase_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_SETUP,
    OP_DIV_2DM,
    OP_DIV_3DM,
    OP_DIV_DM,
    OP_DIV_QUOT,
    OP_WR_A,
    OP_WR_B,
    OP_WR_C,
    OP_TIME,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MUL_END,
    OP_ADD_B,
    OP_ADD_C,
    OP_CONV,
    OP_OFFS,
    OP_OUT
  } ctg_op_e;

  typedef struct packed {
    ctg_op_e op;
  } ctg_cmd_t;

  typedef struct packed {
    logic div_done;
    logic dur_zero;
    logic smooth;
    logic lat_zero;
    logic out_busy;
  } ctg_status_t;

endpackage

// ----- src/cubic_trajectory_generator_core.sv -----
// cubic_trajectory_generator_core: point-to-point cubic/linear setpoint generator
// tick item: 3 split multiplies by elapsed time in Horner form
// start item: five divisions by the bit-serial divider in smooth mode,
// one division in linear mode, none on zero duration
// one item at a time; the result register lets the next item in while it waits
// asynchronous active-low reset clears configuration, trajectory state and control
module cubic_trajectory_generator_core #(
  parameter int unsigned FRACTION_BITS = ctg_pkg::FRACTION_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic signed [31:0]             time_step_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             target_position_o,
  output logic                           finished_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ctg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  ctg_pkg::ctg_cmd_t    cmd;
  ctg_pkg::ctg_status_t status;

  // configuration transfers are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer: one datapath operation per cycle, none while it waits on the divider or the result channel
  ctg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .mode_i    (mode_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // registers, multiplier halves, divider and result register
  ctg_dp #(.FracBits(FRACTION_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .time_step_i      (time_step_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .target_position_o(target_position_o),
    .finished_o       (finished_o)
  );

endmodule

// ----- src/ctg_div.sv -----
// ctg_div: bit-serial restoring divider, min(floor(num * 2^F / den), 2^63-1)
// one quotient bit per cycle; uses ctg_pkg
module ctg_div #(
  parameter int unsigned FracBits = ctg_pkg::FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic [63:0] quot_o,
  output logic        done_o
);

  localparam int unsigned NB = 64 + FracBits;
  localparam int unsigned CW = $clog2(NB + 1);

  logic [NB-1:0] num_q, num_d;
  logic [31:0]   rem_q, rem_d;
  logic [62:0]   quo_q, quo_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [32:0]   trial;
  logic          ge;

  assign trial = {rem_q, num_q[NB-1]};
  assign ge    = trial >= {1'b0, den_i};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = {num_i, {FracBits{1'b0}}};
      rem_d  = '0;
      quo_d  = '0;
      ovf_d  = 1'b0;
      cnt_d  = CW'(NB);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      rem_d = ge ? 32'(trial - {1'b0, den_i}) : trial[31:0];
      quo_d = {quo_q[61:0], ge};
      ovf_d = ovf_q | quo_q[62];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign quot_o = ovf_q ? ctg_pkg::COEF_MAX : {1'b0, quo_q};
  assign done_o = done_q;

endmodule

// ----- src/ctg_dp.sv -----
// ctg_dp: datapath with configuration registers, trajectory state,
// split multiplier, saturating adders and the divider; uses ctg_pkg, ctg_div
module ctg_dp #(
  parameter int unsigned FracBits = ctg_pkg::FRACTION_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ctg_pkg::ctg_cmd_t              cmd_i,
  output ctg_pkg::ctg_status_t           status_o,
  input  logic                           cfg_we_i,
  input  logic [ctg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic signed [31:0]             time_step_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [31:0]             target_position_o,
  output logic                           finished_o
);

  localparam int unsigned SH = 32 - FracBits;
  localparam logic signed [64:0] MAX65 = {1'b0, ctg_pkg::COEF_MAX};

  logic signed [31:0] start_q, end_q;
  logic [31:0]        dur_q;
  logic               smooth_q;

  logic [31:0]        elapsed_q, lat_q, step_q;
  logic signed [63:0] a_q, b_q, c_q, acc_q;
  logic signed [31:0] offset_q, target_q;
  logic [63:0]        dm_q;
  logic               neg_q;
  logic [63:0]        plo_q;
  logic [62:0]        phi_q;
  logic               out_valid_q, out_fin_q;
  logic signed [31:0] out_target_q;

  // setup
  logic signed [32:0] diff;
  logic [32:0]        dmag;
  assign diff = {start_q[31], start_q} - {end_q[31], end_q};
  assign dmag = diff[32] ? 33'(-diff) : 33'(diff);

  // divider
  logic        div_start;
  logic [63:0] div_num, div_quot;
  logic        div_done;

  always_comb begin
    div_start = 1'b1;
    div_num   = dm_q;
    case (cmd_i.op)
      ctg_pkg::OP_DIV_2DM:  div_num = dm_q << 1;
      ctg_pkg::OP_DIV_3DM:  div_num = dm_q + (dm_q << 1);
      ctg_pkg::OP_DIV_DM:   div_num = dm_q;
      ctg_pkg::OP_DIV_QUOT: div_num = div_quot;
      default:              div_start = 1'b0;
    endcase
  end

  ctg_div #(.FracBits(FracBits)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (lat_q),
    .quot_o (div_quot),
    .done_o (div_done)
  );

  // time update with clamp to [0, T]
  logic signed [33:0] tsum;
  logic [31:0]        tnew;
  assign tsum = $signed({2'b00, elapsed_q}) + 34'($signed(step_q));

  always_comb begin
    if (tsum > $signed({2'b00, lat_q})) begin
      tnew = lat_q;
    end else if (tsum[33]) begin
      tnew = '0;
    end else begin
      tnew = tsum[31:0];
    end
  end

  // magnitude multiply by elapsed time, split in a 32-bit low half and a 31-bit high half
  logic [63:0] mag;
  logic [63:0] plo_prod;
  logic [62:0] phi_prod;
  logic [95:0] full;
  logic [95:0] shifted;
  logic [62:0] mres;
  assign mag      = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
  assign plo_prod = mag[31:0] * elapsed_q;
  assign phi_prod = mag[62:32] * elapsed_q;
  assign full     = {1'b0, phi_q, 32'b0} + {32'b0, plo_q};
  assign shifted  = full >> FracBits;
  assign mres     = (shifted[95:63] != '0) ? ctg_pkg::COEF_MAX[62:0] : shifted[62:0];

  // saturating add of a coefficient
  logic signed [63:0] addend;
  logic signed [64:0] sum65;
  logic signed [63:0] sat_sum;
  assign addend = (cmd_i.op == ctg_pkg::OP_ADD_B) ? b_q : c_q;
  assign sum65  = {acc_q[63], acc_q} + {addend[63], addend};
  always_comb begin
    if (sum65 > MAX65) begin
      sat_sum = ctg_pkg::COEF_MAX;
    end else if (sum65 < -MAX65) begin
      sat_sum = -ctg_pkg::COEF_MAX;
    end else begin
      sat_sum = sum65[63:0];
    end
  end

  // conversion to position and offset
  logic [63:0]        pm;
  logic signed [64:0] pos65;
  logic signed [31:0] sat32;
  assign pm    = mag >> SH;
  assign pos65 = {acc_q[63], acc_q} + 65'(offset_q);
  always_comb begin
    if (pos65 > 65'sh0_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (pos65 < -65'sh0_8000_0000) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = pos65[31:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      end_q    <= '0;
      dur_q    <= '0;
      smooth_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ctg_pkg::REG_START:  start_q  <= cfg_data_i;
        ctg_pkg::REG_END:    end_q    <= cfg_data_i;
        ctg_pkg::REG_DUR:    dur_q    <= cfg_data_i;
        ctg_pkg::REG_SMOOTH: smooth_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // trajectory state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      lat_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      c_q         <= '0;
      offset_q    <= '0;
      target_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        ctg_pkg::OP_SETUP: begin
          elapsed_q <= '0;
          lat_q     <= dur_q;
          a_q       <= '0;
          b_q       <= '0;
          c_q       <= '0;
          if (dur_q == '0) begin
            offset_q <= '0;
            target_q <= end_q;
          end else begin
            offset_q <= start_q;
            target_q <= start_q;
          end
        end
        ctg_pkg::OP_WR_A: a_q <= neg_q ? -$signed(div_quot) : $signed(div_quot);
        ctg_pkg::OP_WR_B: b_q <= neg_q ? $signed(div_quot) : -$signed(div_quot);
        ctg_pkg::OP_WR_C: c_q <= neg_q ? $signed(div_quot) : -$signed(div_quot);
        ctg_pkg::OP_TIME: elapsed_q <= tnew;
        ctg_pkg::OP_OFFS: target_q <= sat32;
        default: ;
      endcase
      if (cmd_i.op == ctg_pkg::OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ctg_pkg::OP_LATCH:   step_q <= time_step_i;
      ctg_pkg::OP_SETUP: begin
        dm_q  <= 64'(dmag) << SH;
        neg_q <= diff[32];
      end
      ctg_pkg::OP_TIME:    acc_q <= a_q;
      ctg_pkg::OP_MUL_LO:  plo_q <= plo_prod;
      ctg_pkg::OP_MUL_HI:  phi_q <= phi_prod;
      ctg_pkg::OP_MUL_END: acc_q <= acc_q[63] ? -$signed({1'b0, mres}) : $signed({1'b0, mres});
      ctg_pkg::OP_ADD_B,
      ctg_pkg::OP_ADD_C:   acc_q <= sat_sum;
      ctg_pkg::OP_CONV:    acc_q <= acc_q[63] ? -$signed(pm) : $signed(pm);
      ctg_pkg::OP_OUT: begin
        out_target_q <= target_q;
        out_fin_q    <= elapsed_q >= lat_q;
      end
      default: ;
    endcase
  end

  assign status_o.div_done = div_done;
  assign status_o.dur_zero = (dur_q == '0);
  assign status_o.smooth   = smooth_q;
  assign status_o.lat_zero = (lat_q == '0);
  assign status_o.out_busy = out_valid_q & ~out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign target_position_o = out_target_q;
  assign finished_o        = out_fin_q;

endmodule

// ----- src/ctg_ctrl.sv -----
// ctg_ctrl: sequencing state machine for start and tick items
// issues one datapath operation per cycle, none while it waits on the divider or the result channel; uses ctg_pkg
module ctg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 mode_i,
  output logic                 in_ready_o,
  input  ctg_pkg::ctg_status_t status_i,
  output ctg_pkg::ctg_cmd_t    cmd_o
);

  ctg_pkg::ctg_state_e state_q, state_d;
  ctg_pkg::ctg_phase_e phase_q, phase_d;
  logic [1:0]          left_q, left_d;
  logic                first_q, first_d;
  logic [1:0]          mulk_q, mulk_d;

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    left_d  = left_q;
    first_d = first_q;
    mulk_d  = mulk_q;
    case (state_q)
      ctg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = mode_i ? ctg_pkg::ST_SETUP : ctg_pkg::ST_TIME;
        end
      end
      ctg_pkg::ST_SETUP: begin
        first_d = 1'b1;
        if (status_i.dur_zero) begin
          state_d = ctg_pkg::ST_DONE;
        end else if (status_i.smooth) begin
          phase_d = ctg_pkg::PH_A;
          left_d  = 2'd3;
          state_d = ctg_pkg::ST_DIV_GO;
        end else begin
          phase_d = ctg_pkg::PH_C;
          left_d  = 2'd1;
          state_d = ctg_pkg::ST_DIV_GO;
        end
      end
      ctg_pkg::ST_DIV_GO: begin
        first_d = 1'b0;
        left_d  = left_q - 2'd1;
        state_d = ctg_pkg::ST_DIV_WAIT;
      end
      ctg_pkg::ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          if (left_q != 2'd0) begin
            state_d = ctg_pkg::ST_DIV_GO;
          end else if (phase_q == ctg_pkg::PH_A) begin
            phase_d = ctg_pkg::PH_B;
            left_d  = 2'd2;
            first_d = 1'b1;
            state_d = ctg_pkg::ST_DIV_GO;
          end else begin
            state_d = ctg_pkg::ST_DONE;
          end
        end
      end
      ctg_pkg::ST_TIME: begin
        mulk_d  = 2'd0;
        state_d = status_i.lat_zero ? ctg_pkg::ST_DONE : ctg_pkg::ST_MUL_LO;
      end
      ctg_pkg::ST_MUL_LO:  state_d = ctg_pkg::ST_MUL_HI;
      ctg_pkg::ST_MUL_HI:  state_d = ctg_pkg::ST_MUL_END;
      ctg_pkg::ST_MUL_END: state_d = (mulk_q == 2'd2) ? ctg_pkg::ST_CONV : ctg_pkg::ST_ADD;
      ctg_pkg::ST_ADD: begin
        mulk_d  = mulk_q + 2'd1;
        state_d = ctg_pkg::ST_MUL_LO;
      end
      ctg_pkg::ST_CONV: state_d = ctg_pkg::ST_OFFS;
      ctg_pkg::ST_OFFS: state_d = ctg_pkg::ST_DONE;
      ctg_pkg::ST_DONE: begin
        if (!status_i.out_busy) begin
          state_d = ctg_pkg::ST_IDLE;
        end
      end
      default: state_d = ctg_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op   = ctg_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ctg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = ctg_pkg::OP_LATCH;
        end
      end
      ctg_pkg::ST_SETUP: cmd_o.op = ctg_pkg::OP_SETUP;
      ctg_pkg::ST_DIV_GO: begin
        if (!first_q) begin
          cmd_o.op = ctg_pkg::OP_DIV_QUOT;
        end else begin
          case (phase_q)
            ctg_pkg::PH_A: cmd_o.op = ctg_pkg::OP_DIV_2DM;
            ctg_pkg::PH_B: cmd_o.op = ctg_pkg::OP_DIV_3DM;
            default:       cmd_o.op = ctg_pkg::OP_DIV_DM;
          endcase
        end
      end
      ctg_pkg::ST_DIV_WAIT: begin
        if (status_i.div_done && left_q == 2'd0) begin
          case (phase_q)
            ctg_pkg::PH_A: cmd_o.op = ctg_pkg::OP_WR_A;
            ctg_pkg::PH_B: cmd_o.op = ctg_pkg::OP_WR_B;
            default:       cmd_o.op = ctg_pkg::OP_WR_C;
          endcase
        end
      end
      ctg_pkg::ST_TIME:    cmd_o.op = ctg_pkg::OP_TIME;
      ctg_pkg::ST_MUL_LO:  cmd_o.op = ctg_pkg::OP_MUL_LO;
      ctg_pkg::ST_MUL_HI:  cmd_o.op = ctg_pkg::OP_MUL_HI;
      ctg_pkg::ST_MUL_END: cmd_o.op = ctg_pkg::OP_MUL_END;
      ctg_pkg::ST_ADD:     cmd_o.op = (mulk_q == 2'd0) ? ctg_pkg::OP_ADD_B : ctg_pkg::OP_ADD_C;
      ctg_pkg::ST_CONV:    cmd_o.op = ctg_pkg::OP_CONV;
      ctg_pkg::ST_OFFS:    cmd_o.op = ctg_pkg::OP_OFFS;
      ctg_pkg::ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.op = ctg_pkg::OP_OUT;
        end
      end
      default: cmd_o.op = ctg_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctg_pkg::ST_IDLE;
      phase_q <= ctg_pkg::PH_A;
      left_q  <= '0;
      first_q <= 1'b0;
      mulk_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      left_q  <= left_d;
      first_q <= first_d;
      mulk_q  <= mulk_d;
    end
  end

endmodule
